// File: hw/rtl/clcd_pkg.sv
// Package for the character LCD cursor translator.
// Holds character codes, LCD command bytes, queue sizes and the beat, decode and queue status types.
// Depends on nothing.
package clcd_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_CLEAR   = 8'h40;
  localparam logic [7:0] CH_ROW     = 8'h5E;
  localparam logic [7:0] CH_LEFT    = 8'h3C;
  localparam logic [7:0] CH_RIGHT   = 8'h3E;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;
  localparam logic [7:0] CMD_SHIFT_RGHT = 8'h14;
  localparam logic [7:0] CMD_ROW2_START = 8'hC0;
  localparam logic [7:0] CMD_ROW2_END   = 8'hCF;
  localparam logic [7:0] CMD_ROW1_END   = 8'h8F;
  localparam logic [7:0] ROW1_OFFSET    = 8'h70;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       reg_select;
    logic       last;
  } lcd_beat_t;

  typedef struct packed {
    logic [1:0] cnt;
    lcd_beat_t  beat0;
    lcd_beat_t  beat1;
    logic [4:0] cursor_nxt;
  } dec_out_t;

  typedef struct packed {
    logic [QCW-1:0] level;
    logic           room2;
  } q_stat_t;

endpackage

// File: hw/rtl/clcd_decode.sv
// Decoder that maps one character and the current cursor to LCD writes.
// Uses types and constants from clcd_pkg.
module clcd_decode (
  input  logic [7:0]        ch,
  input  logic [4:0]        cursor,
  output clcd_pkg::dec_out_t dec
);

  logic [5:0] pos;
  logic [7:0] b0;
  logic       rs0;
  logic       first;
  logic       second;
  logic [7:0] b1;

  always_comb begin
    pos   = {1'b0, cursor};
    b0    = clcd_pkg::CMD_CLEAR;
    rs0   = 1'b0;
    first = 1'b1;
    case (ch)
      clcd_pkg::CH_NEWLINE: begin
        first = 1'b0;
      end
      clcd_pkg::CH_CLEAR: begin
        b0  = clcd_pkg::CMD_CLEAR;
        pos = 6'd0;
      end
      clcd_pkg::CH_ROW: begin
        if (!cursor[4]) begin
          b0  = {3'b000, cursor} + clcd_pkg::CMD_ROW2_START;
          pos = {1'b0, cursor} + 6'd16;
        end else begin
          b0  = {3'b000, cursor} + clcd_pkg::ROW1_OFFSET;
          pos = {1'b0, cursor} - 6'd16;
        end
      end
      clcd_pkg::CH_LEFT: begin
        if (cursor == 5'd0) begin
          b0  = clcd_pkg::CMD_ROW2_END;
          pos = 6'd31;
        end else if (cursor == 5'd16) begin
          b0  = clcd_pkg::CMD_ROW1_END;
          pos = 6'd15;
        end else begin
          b0  = clcd_pkg::CMD_SHIFT_LEFT;
          pos = {1'b0, cursor} - 6'd1;
        end
      end
      clcd_pkg::CH_RIGHT: begin
        if (cursor == 5'd15) begin
          b0  = clcd_pkg::CMD_ROW2_START;
          pos = 6'd16;
        end else if (cursor == 5'd31) begin
          b0  = clcd_pkg::CMD_HOME;
          pos = 6'd0;
        end else begin
          b0  = clcd_pkg::CMD_SHIFT_RGHT;
          pos = {1'b0, cursor} + 6'd1;
        end
      end
      default: begin
        b0  = ch;
        rs0 = 1'b1;
        pos = {1'b0, cursor} + 6'd1;
      end
    endcase

    second = 1'b0;
    b1     = clcd_pkg::CMD_ROW2_START;
    if (first && pos == 6'd16) begin
      second = 1'b1;
    end else if (first && pos == 6'd32) begin
      second = 1'b1;
      b1     = clcd_pkg::CMD_HOME;
    end

    dec.cnt              = {1'b0, first} + {1'b0, second};
    dec.beat0.lcd_byte   = b0;
    dec.beat0.reg_select = rs0;
    dec.beat0.last       = !second;
    dec.beat1.lcd_byte   = b1;
    dec.beat1.reg_select = 1'b0;
    dec.beat1.last       = 1'b1;
    dec.cursor_nxt       = first ? pos[4:0] : cursor;
  end

endmodule

// File: hw/rtl/clcd_queue.sv
// Four-entry result queue that takes up to two beats per cycle and gives at most one, while pop is set.
// Uses types and constants from clcd_pkg.
module clcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_cnt,
  input  clcd_pkg::lcd_beat_t push0,
  input  clcd_pkg::lcd_beat_t push1,
  input  logic                pop,
  output clcd_pkg::lcd_beat_t head,
  output logic                head_valid,
  output clcd_pkg::q_stat_t   stat
);

  clcd_pkg::lcd_beat_t              mem_r [clcd_pkg::QDEPTH];
  logic [clcd_pkg::QAW-1:0]         wr_ptr_r;
  logic [clcd_pkg::QAW-1:0]         wr_ptr_nxt;
  logic [clcd_pkg::QAW-1:0]         rd_ptr_r;
  logic [clcd_pkg::QAW-1:0]         rd_ptr_nxt;
  logic [clcd_pkg::QCW-1:0]         level_r;
  logic [clcd_pkg::QCW-1:0]         level_nxt;
  logic [clcd_pkg::QAW-1:0]         wr_ptr1;
  logic                             do_pop;

  assign do_pop     = pop && (level_r != '0);
  assign wr_ptr1    = wr_ptr_r + clcd_pkg::QAW'(1);
  assign wr_ptr_nxt = wr_ptr_r + push_cnt;
  assign rd_ptr_nxt = rd_ptr_r + clcd_pkg::QAW'(do_pop);
  assign level_nxt  = level_r + clcd_pkg::QCW'(push_cnt) - clcd_pkg::QCW'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr1] <= push1;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (level_r != '0);
  assign stat.level = level_r;
  assign stat.room2 = (level_r <= clcd_pkg::QCW'(clcd_pkg::QDEPTH - 2));

endmodule

// File: hw/rtl/char_lcd_cursor_translator.sv
// Top level of the character LCD cursor translator.
// Instantiates clcd_decode and clcd_queue; uses clcd_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, in_ch) carries one character
//   per beat. The output channel (out_valid, out_stall, out_lcd_byte,
//   out_reg_select, out_last) carries one LCD controller write per beat;
//   out_last marks the final write caused by a character, and a newline
//   causes no write at all.
//   A character is decoded against the cursor register in the cycle it is
//   accepted and its writes enter a four-entry result queue, where they are
//   registered and reach the output behind any writes still queued.
//   One character is accepted per cycle while each causes at most one write
//   and out_stall is low; characters with two writes fill the queue faster
//   than the single output beat per cycle drains it. in_stall is raised while
//   the queue has fewer than two free entries.
//   When the receiver holds out_stall, the head write stays on the output
//   and the queue fills until the input stalls. Synchronous reset empties
//   the queue and sets the cursor to zero.
module char_lcd_cursor_translator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_lcd_byte,
  output logic       out_reg_select,
  output logic       out_last
);

  clcd_pkg::dec_out_t  dec;
  clcd_pkg::lcd_beat_t head;
  clcd_pkg::q_stat_t   stat;
  logic [4:0]          cursor_r;
  logic [4:0]          cursor_nxt;
  logic                in_acc;
  logic [1:0]          push_cnt;

  clcd_decode u_decode (
    .ch     (in_ch),
    .cursor (cursor_r),
    .dec    (dec)
  );

  assign in_stall   = !stat.room2;
  assign in_acc     = in_valid && !in_stall;
  assign push_cnt   = in_acc ? dec.cnt : 2'd0;
  assign cursor_nxt = in_acc ? dec.cursor_nxt : cursor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= 5'd0;
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

  clcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (dec.beat0),
    .push1      (dec.beat1),
    .pop        (!out_stall),
    .head       (head),
    .head_valid (out_valid),
    .stat       (stat)
  );

  assign out_lcd_byte   = head.lcd_byte;
  assign out_reg_select = head.reg_select;
  assign out_last       = head.last;

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= 3'(clcd_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch != clcd_pkg::CH_NEWLINE |=> out_valid)
    else $error("accepted character produced no write");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch == clcd_pkg::CH_CLEAR |=> cursor_r == 5'd0)
    else $error("clear did not reset the cursor");

  a_newline_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch == clcd_pkg::CH_NEWLINE |=> $stable(cursor_r))
    else $error("newline moved the cursor");
`endif

endmodule
